FILE: rtl/core/wsfu_pkg.sv
// wsfu_pkg: types and constants for the websocket frame unmasker
// no dependencies; imported by websocket_frame_unmasker

package wsfu_pkg;

    localparam logic [7:0]  MASK_BIT        = 8'h80;
    localparam logic [6:0]  LEN_16          = 7'd126;
    localparam logic [6:0]  LEN_64          = 7'd127;
    localparam logic [3:0]  HDR_EXT16_BYTES = 4'd2;
    localparam logic [3:0]  HDR_EXT64_BYTES = 4'd8;
    localparam logic [3:0]  HDR_MASK_BYTES  = 4'd4;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd4096;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PASS  = 2'd1,
        ST_LARGE = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_LEN     = 7'b0000010,
        PH_EXT     = 7'b0000100,
        PH_MASK    = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_PASS    = 7'b0100000,
        PH_DRAIN   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        status_t    status;
    } res_t;

endpackage

FILE: rtl/core/websocket_frame_unmasker.sv
// websocket_frame_unmasker: single-frame receive decoder and payload unmasker
// depends on wsfu_pkg
//
// channel   dir  handshake               content
// s_axis    in   s_axis_tvalid/tready    tdata = data_byte, tlast = buffer_end
// m_axis    out  m_axis_tvalid/tready    tdata = out_byte, tlast = last,
//                                        tuser = {status, has_byte}
// cfg       in   cfg_valid/cfg_ready     cfg_data = max_payload
//
// one byte per cycle in unless stalled; a byte is first held in the input register,
// then its results enter a four-entry result queue that drives the output. each queue
// entry leaves as an output transfer of its own, so a byte that gives two results
// costs one extra output transfer. the input register holds its byte while the queue
// holds more than two results, so a blocked output side stalls the input only once
// the queue has filled that far.
// reset returns to idle with max_payload 4096 and an empty queue.

module websocket_frame_unmasker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser,   // [0] has_byte, [2:1] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import wsfu_pkg::*;

    localparam int QDEPTH = 4;

    logic [31:0] max_payload_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    phase_t      phase_reg,     phase_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [3:0]  hdr_cnt_reg,   hdr_cnt_next;
    logic [63:0] ext_len_reg,   ext_len_next;
    logic [31:0] mask_key_reg,  mask_key_next;
    logic [31:0] remain_reg,    remain_next;
    logic [1:0]  mask_idx_reg,  mask_idx_next;

    res_t        queue_reg [QDEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        proc_fire;
    logic        in_fire;
    logic        out_fire;
    logic [1:0]  n_push;
    res_t        res0;
    res_t        res1;
    res_t        head;

    assign cfg_ready     = 1'b1;
    assign proc_fire     = in_valid_reg && (count_reg <= 3'd2);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_axis_tdata  = head.out_byte;
    assign m_axis_tlast  = head.last;
    assign m_axis_tuser  = {head.status, head.has_byte};
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        logic [6:0] len7;
        logic [7:0] key;
        logic       too_large;
        logic       done;

        len7            = in_byte_reg[6:0];
        key             = 8'd0;
        too_large       = (ext_len_reg[63:32] != 32'd0) ||
                          (ext_len_reg[31:0] >= max_payload_reg);
        done            = (remain_reg == 32'd1);
        phase_next      = phase_reg;
        first_byte_next = first_byte_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        ext_len_next    = ext_len_reg;
        mask_key_next   = mask_key_reg;
        remain_next     = remain_reg;
        mask_idx_next   = mask_idx_reg;
        n_push          = 2'd0;
        res0            = '{out_byte: 8'd0, has_byte: 1'b0, last: 1'b1, status: ST_TRUNC};
        res1            = '{out_byte: 8'd0, has_byte: 1'b0, last: 1'b1, status: ST_TRUNC};

        case (phase_reg)
            PH_IDLE:
            begin
                first_byte_next = in_byte_reg;
                if (in_end_reg)
                begin
                    n_push = 2'd1;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if ((in_byte_reg & MASK_BIT) == 8'd0)
                begin
                    res0 = '{out_byte: first_byte_reg, has_byte: 1'b1, last: 1'b0,
                             status: ST_PASS};
                    res1 = '{out_byte: in_byte_reg, has_byte: 1'b1, last: in_end_reg,
                             status: ST_PASS};
                    n_push     = 2'd2;
                    phase_next = in_end_reg ? PH_IDLE : PH_PASS;
                end
                else
                begin
                    mask_key_next = 32'd0;
                    if (len7 < LEN_16)
                    begin
                        ext_len_next = {57'd0, len7};
                        hdr_cnt_next = HDR_MASK_BYTES;
                        phase_next   = PH_MASK;
                    end
                    else
                    begin
                        ext_len_next = 64'd0;
                        hdr_cnt_next = (len7 == LEN_64) ? HDR_EXT64_BYTES : HDR_EXT16_BYTES;
                        phase_next   = PH_EXT;
                    end
                    if (in_end_reg)
                    begin
                        n_push     = 2'd1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_EXT:
            begin
                ext_len_next = {ext_len_reg[55:0], in_byte_reg};
                hdr_cnt_next = hdr_cnt_reg - 4'd1;
                if (hdr_cnt_reg == 4'd1)
                begin
                    hdr_cnt_next = HDR_MASK_BYTES;
                    phase_next   = PH_MASK;
                end
                if (in_end_reg)
                begin
                    n_push     = 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], in_byte_reg};
                hdr_cnt_next  = hdr_cnt_reg - 4'd1;
                if (hdr_cnt_reg == 4'd1)
                begin
                    if (too_large || (ext_len_reg == 64'd0))
                    begin
                        res0.status = too_large ? ST_LARGE : ST_OK;
                        n_push      = 2'd1;
                        phase_next  = in_end_reg ? PH_IDLE : PH_DRAIN;
                    end
                    else
                    begin
                        remain_next   = ext_len_reg[31:0];
                        mask_idx_next = 2'd0;
                        if (in_end_reg)
                        begin
                            n_push     = 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                else if (in_end_reg)
                begin
                    n_push     = 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_PAYLOAD:
            begin
                case (mask_idx_reg)
                    2'd0:    key = mask_key_reg[31:24];
                    2'd1:    key = mask_key_reg[23:16];
                    2'd2:    key = mask_key_reg[15:8];
                    default: key = mask_key_reg[7:0];
                endcase
                mask_idx_next = mask_idx_reg + 2'd1;
                remain_next   = remain_reg - 32'd1;
                res0 = '{out_byte: in_byte_reg ^ key, has_byte: 1'b1, last: done,
                         status: ST_OK};
                n_push = 2'd1;
                if (done)
                begin
                    phase_next = in_end_reg ? PH_IDLE : PH_DRAIN;
                end
                else if (in_end_reg)
                begin
                    n_push     = 2'd2;
                    phase_next = PH_IDLE;
                end
            end
            PH_PASS:
            begin
                res0 = '{out_byte: in_byte_reg, has_byte: 1'b1, last: in_end_reg,
                         status: ST_PASS};
                n_push = 2'd1;
                if (in_end_reg)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DRAIN:
            begin
                if (in_end_reg)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_payload_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            first_byte_reg <= 8'd0;
            hdr_cnt_reg    <= 4'd0;
            ext_len_reg    <= 64'd0;
            mask_key_reg   <= 32'd0;
            remain_reg     <= 32'd0;
            mask_idx_reg   <= 2'd0;
        end
        else if (proc_fire)
        begin
            phase_reg      <= phase_next;
            first_byte_reg <= first_byte_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            ext_len_reg    <= ext_len_next;
            mask_key_reg   <= mask_key_next;
            remain_reg     <= remain_next;
            mask_idx_reg   <= mask_idx_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (proc_fire && (n_push != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (proc_fire && (n_push == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (proc_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_push;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (proc_fire ? {1'b0, n_push} : 3'd0)
                         - {2'b00, out_fire};
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("status-only result without last");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_end_reg |=> phase_reg == PH_IDLE)
        else $error("buffer end did not return parser to idle");

    a_payload_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != 32'd0)
        else $error("payload phase with nothing remaining");

endmodule
